FILE: src/ckb_pkg.sv
`timescale 1ns / 1ps

package ckb_pkg;

    localparam int LINE_PITCH    = 640;
    localparam int COORD_BITS    = 10;
    localparam int ADDR_BITS     = 20;
    localparam int PIXEL_BITS    = 8;
    localparam int MODE_BITS     = 2;
    localparam int SCREEN_W_BITS = $clog2(LINE_PITCH + 1);
    localparam int PROD_BITS     = COORD_BITS + SCREEN_W_BITS + 1;
    localparam int CFG_DATA_BITS = (COORD_BITS > PIXEL_BITS) ? COORD_BITS : PIXEL_BITS;
    localparam int CFG_INDEX_BITS = 4;
    localparam int OUT_DATA_BITS = ((ADDR_BITS + PIXEL_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DEST_X      = 4'd0,
        REG_DEST_Y      = 4'd1,
        REG_RECT_WIDTH  = 4'd2,
        REG_RECT_HEIGHT = 4'd3,
        REG_SOURCE_SKIP = 4'd4,
        REG_DEST_SKIP   = 4'd5,
        REG_DRAW_MODE   = 4'd6,
        REG_FILL_COLOUR = 4'd7
    } reg_index_t;

    localparam logic [MODE_BITS-1:0] MODE_KEY_FILL   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_KEY_SOURCE = 2'd1;

    // Frame buffer offset of the top-left pixel, wrapped to the address width.
    function automatic logic [ADDR_BITS-1:0] start_address(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y
    );
        logic [PROD_BITS-1:0] sum;
        sum = PROD_BITS'(y) * PROD_BITS'(LINE_PITCH) + PROD_BITS'(x);
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

FILE: src/color_key_sprite_blitter.sv
`timescale 1ns / 1ps

// Each write item is registered: it reaches the master side in the cycle after its source.
// Throughput: one source item per cycle while the master side is not stalled; the counter
// and pointer update is a single add-and-compare step ahead of the output register, and the
// start address multiply sits only in the configuration write path.
// Reset (aresetn low, synchronous) clears the configuration, the counters and the output
// valid flag, and starts an empty run; the output data registers are left as they are.
module color_key_sprite_blitter
    import ckb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [PIXEL_BITS-1:0]     s_tdata,   // [7:0] source_pixel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,   // [19:0] write_address, [27:20] write_value
    output logic                      m_tuser,   // [0] write_enable
    output logic                      m_tlast    // last_pixel
);

    logic [COORD_BITS-1:0] dest_x_reg, dest_x_next;
    logic [COORD_BITS-1:0] dest_y_reg, dest_y_next;
    logic [COORD_BITS-1:0] rect_width_reg, rect_width_next;
    logic [COORD_BITS-1:0] rect_height_reg, rect_height_next;
    logic [COORD_BITS-1:0] source_skip_reg, source_skip_next;
    logic [COORD_BITS-1:0] dest_skip_reg, dest_skip_next;
    logic [MODE_BITS-1:0]  draw_mode_reg, draw_mode_next;
    logic [PIXEL_BITS-1:0] fill_colour_reg, fill_colour_next;
    logic [ADDR_BITS-1:0]  start_addr_reg, start_addr_next;

    logic [COORD_BITS-1:0] column_count_reg, column_count_next;
    logic [COORD_BITS-1:0] row_count_reg, row_count_next;
    logic [COORD_BITS-1:0] skip_count_reg, skip_count_next;
    logic [ADDR_BITS-1:0]  dest_pointer_reg, dest_pointer_next;
    logic                  in_skip_reg, in_skip_next;

    logic                  m_valid_reg, m_valid_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [PIXEL_BITS-1:0] value_reg, value_next;
    logic                  enable_reg, enable_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic                  cfg_hit;
    logic [COORD_BITS-1:0] col_inc, row_inc, skip_inc;
    logic [ADDR_BITS-1:0]  ptr_inc;
    logic [PIXEL_BITS-1:0] pix;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pix      = s_tdata;

    assign col_inc  = column_count_reg + COORD_BITS'(1);
    assign row_inc  = row_count_reg + COORD_BITS'(1);
    assign skip_inc = skip_count_reg + COORD_BITS'(1);
    assign ptr_inc  = dest_pointer_reg + ADDR_BITS'(1);

    always_comb begin
        dest_x_next      = dest_x_reg;
        dest_y_next      = dest_y_reg;
        rect_width_next  = rect_width_reg;
        rect_height_next = rect_height_reg;
        source_skip_next = source_skip_reg;
        dest_skip_next   = dest_skip_reg;
        draw_mode_next   = draw_mode_reg;
        fill_colour_next = fill_colour_reg;
        cfg_hit          = 1'b0;
        if (cfg_we) begin
            cfg_hit = 1'b1;
            case (cfg_index)
                REG_DEST_X:      dest_x_next      = cfg_wdata[COORD_BITS-1:0];
                REG_DEST_Y:      dest_y_next      = cfg_wdata[COORD_BITS-1:0];
                REG_RECT_WIDTH:  rect_width_next  = cfg_wdata[COORD_BITS-1:0];
                REG_RECT_HEIGHT: rect_height_next = cfg_wdata[COORD_BITS-1:0];
                REG_SOURCE_SKIP: source_skip_next = cfg_wdata[COORD_BITS-1:0];
                REG_DEST_SKIP:   dest_skip_next   = cfg_wdata[COORD_BITS-1:0];
                REG_DRAW_MODE:   draw_mode_next   = cfg_wdata[MODE_BITS-1:0];
                REG_FILL_COLOUR: fill_colour_next = cfg_wdata[PIXEL_BITS-1:0];
                default:         cfg_hit          = 1'b0;
            endcase
        end
        start_addr_next = start_address(dest_x_next, dest_y_next);
    end

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        skip_count_next   = skip_count_reg;
        dest_pointer_next = dest_pointer_reg;
        in_skip_next      = in_skip_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        addr_next         = addr_reg;
        value_next        = value_reg;
        enable_next       = enable_reg;
        last_next         = last_reg;

        if (cfg_hit) begin
            // Any write to a known register aborts the run and reloads the start address.
            column_count_next = '0;
            row_count_next    = '0;
            skip_count_next   = '0;
            in_skip_next      = 1'b0;
            dest_pointer_next = start_addr_next;
        end else if (accept && rect_width_reg != '0 && rect_height_reg != '0) begin
            if (in_skip_reg) begin
                if (skip_inc >= source_skip_reg) begin
                    in_skip_next    = 1'b0;
                    skip_count_next = '0;
                end else begin
                    skip_count_next = skip_inc;
                end
            end else begin
                m_valid_next = 1'b1;
                addr_next    = dest_pointer_reg;
                last_next    = 1'b0;
                if (draw_mode_reg != MODE_KEY_FILL && draw_mode_reg != MODE_KEY_SOURCE) begin
                    enable_next = 1'b1;
                    value_next  = pix;
                end else if (pix == '0) begin
                    enable_next = 1'b0;
                    value_next  = '0;
                end else begin
                    enable_next = 1'b1;
                    value_next  = (draw_mode_reg == MODE_KEY_SOURCE) ? pix : fill_colour_reg;
                end

                dest_pointer_next = ptr_inc;
                column_count_next = col_inc;
                if (col_inc >= rect_width_reg) begin
                    column_count_next = '0;
                    dest_pointer_next = ptr_inc + ADDR_BITS'(dest_skip_reg);
                    row_count_next    = row_inc;
                    if (row_inc >= rect_height_reg) begin
                        // Final pixel: the next run starts at once with the same setup.
                        last_next         = 1'b1;
                        row_count_next    = '0;
                        skip_count_next   = '0;
                        in_skip_next      = 1'b0;
                        dest_pointer_next = start_addr_reg;
                    end else if (source_skip_reg != '0) begin
                        in_skip_next    = 1'b1;
                        skip_count_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg       <= '0;
            dest_y_reg       <= '0;
            rect_width_reg   <= '0;
            rect_height_reg  <= '0;
            source_skip_reg  <= '0;
            dest_skip_reg    <= '0;
            draw_mode_reg    <= '0;
            fill_colour_reg  <= '0;
            start_addr_reg   <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            skip_count_reg   <= '0;
            dest_pointer_reg <= '0;
            in_skip_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            dest_x_reg       <= dest_x_next;
            dest_y_reg       <= dest_y_next;
            rect_width_reg   <= rect_width_next;
            rect_height_reg  <= rect_height_next;
            source_skip_reg  <= source_skip_next;
            dest_skip_reg    <= dest_skip_next;
            draw_mode_reg    <= draw_mode_next;
            fill_colour_reg  <= fill_colour_next;
            start_addr_reg   <= start_addr_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            skip_count_reg   <= skip_count_next;
            dest_pointer_reg <= dest_pointer_next;
            in_skip_reg      <= in_skip_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        value_reg  <= value_next;
        enable_reg <= enable_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'({value_reg, addr_reg});
    assign m_tuser  = enable_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: bench/tb_color_key_sprite_blitter.sv
`timescale 1ns / 1ps

module tb_color_key_sprite_blitter;
    import ckb_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE_LO = 4'd8;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE_HI = 4'd15;
    localparam logic [MODE_BITS-1:0] MODE_OPAQUE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_SPARE  = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TARGET_ITEMS = 1550;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [PIXEL_BITS-1:0] value;
        logic                  en;
        logic                  last;
    } px_write_t;

    typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_TYPED} check_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        logic [PIXEL_BITS-1:0]     pix;
        check_t                    chk;
        px_write_t                 want;
    } script_row_t;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [PIXEL_BITS-1:0]     s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;

    color_key_sprite_blitter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Blitter state as the testbench sees it.
    logic [COORD_BITS-1:0] pos_x, pos_y, width_px, height_rows, src_gap, dst_gap;
    logic [MODE_BITS-1:0]  mode_sel;
    logic [PIXEL_BITS-1:0] fill_val;
    logic [COORD_BITS-1:0] col_cnt, row_cnt, gap_cnt;
    logic [ADDR_BITS-1:0]  wr_ptr;
    logic                  skipping;

    px_write_t pending_writes[$];
    int        mismatches = 0;
    int        sent_items = 0;
    bit        hold_output = 1'b0;
    bit        source_eager = 1'b0;
    bit        sink_eager = 1'b0;

    script_row_t opening_rows [0:43] = '{
        '{ROW_PIX, '0, '0, 8'h55, CHK_NONE, '0},
        '{ROW_REG, REG_DEST_X, 10'd1023, '0, CHK_PRED, '0},
        '{ROW_REG, REG_DEST_Y, 10'd1023, '0, CHK_PRED, '0},
        '{ROW_REG, REG_RECT_WIDTH, 10'd2, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'hAA, CHK_NONE, '0},
        '{ROW_REG, REG_RECT_HEIGHT, 10'd2, '0, CHK_PRED, '0},
        '{ROW_REG, REG_SOURCE_SKIP, 10'd1, '0, CHK_PRED, '0},
        '{ROW_REG, REG_DEST_SKIP, 10'd1023, '0, CHK_PRED, '0},
        '{ROW_REG, REG_FILL_COLOUR, 10'h3A5, '0, CHK_PRED, '0},
        '{ROW_REG, REG_DRAW_MODE, {8'hC0, MODE_KEY_FILL}, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'hFF, CHK_TYPED, '{20'hA017F, 8'hA5, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, 8'h00, CHK_TYPED, '{20'hA0180, 8'h00, 1'b0, 1'b0}},
        '{ROW_PIX, '0, '0, 8'h80, CHK_NONE, '0},
        '{ROW_PIX, '0, '0, 8'h01, CHK_TYPED, '{20'hA0580, 8'hA5, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, 8'h7F, CHK_TYPED, '{20'hA0581, 8'hA5, 1'b1, 1'b1}},
        '{ROW_PIX, '0, '0, 8'h00, CHK_TYPED, '{20'hA017F, 8'h00, 1'b0, 1'b0}},
        '{ROW_REG, REG_NONE_LO, 10'h3FF, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'h3C, CHK_TYPED, '{20'hA0180, 8'hA5, 1'b1, 1'b0}},
        '{ROW_REG, REG_DRAW_MODE, {8'h00, MODE_KEY_SOURCE}, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'h00, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'hC3, CHK_PRED, '0},
        '{ROW_REG, REG_DRAW_MODE, {8'h00, MODE_OPAQUE}, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'h00, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'hFF, CHK_PRED, '0},
        '{ROW_REG, REG_DRAW_MODE, {8'hFF, MODE_SPARE}, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'h00, CHK_PRED, '0},
        '{ROW_REG, REG_NONE_HI, 10'h000, '0, CHK_PRED, '0},
        '{ROW_REG, REG_DEST_X, 10'd0, '0, CHK_PRED, '0},
        '{ROW_REG, REG_DEST_Y, 10'd0, '0, CHK_PRED, '0},
        '{ROW_REG, REG_RECT_WIDTH, 10'd1023, '0, CHK_PRED, '0},
        '{ROW_REG, REG_RECT_HEIGHT, 10'd1023, '0, CHK_PRED, '0},
        '{ROW_REG, REG_DEST_SKIP, 10'd0, '0, CHK_PRED, '0},
        '{ROW_REG, REG_SOURCE_SKIP, 10'd1023, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'h11, CHK_TYPED, '{20'h00000, 8'h11, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, 8'h00, CHK_PRED, '0},
        '{ROW_REG, REG_RECT_WIDTH, 10'd1, '0, CHK_PRED, '0},
        '{ROW_REG, REG_RECT_HEIGHT, 10'd2, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'h42, CHK_TYPED, '{20'h00000, 8'h42, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, 8'h42, CHK_NONE, '0},
        '{ROW_PIX, '0, '0, 8'h00, CHK_NONE, '0},
        '{ROW_REG, REG_FILL_COLOUR, 10'h000, '0, CHK_PRED, '0},
        '{ROW_REG, REG_DRAW_MODE, {8'h00, MODE_KEY_FILL}, '0, CHK_PRED, '0},
        '{ROW_PIX, '0, '0, 8'h9A, CHK_TYPED, '{20'h00000, 8'h00, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, 8'h00, CHK_PRED, '0}
    };

    function automatic void restart_rect();
        int unsigned base;
        base = int'(pos_y) * LINE_PITCH + int'(pos_x);
        wr_ptr   = base[ADDR_BITS-1:0];
        col_cnt  = '0;
        row_cnt  = '0;
        gap_cnt  = '0;
        skipping = 1'b0;
    endfunction

    function automatic void clear_regs();
        pos_x = '0;  pos_y = '0;  width_px = '0;  height_rows = '0;
        src_gap = '0;  dst_gap = '0;  mode_sel = '0;  fill_val = '0;
        restart_rect();
    endfunction

    // Any known register write aborts the rectangle in progress.
    function automatic void write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_DEST_X:      pos_x = data;
            REG_DEST_Y:      pos_y = data;
            REG_RECT_WIDTH:  width_px = data;
            REG_RECT_HEIGHT: height_rows = data;
            REG_SOURCE_SKIP: src_gap = data;
            REG_DEST_SKIP:   dst_gap = data;
            REG_DRAW_MODE:   mode_sel = data[MODE_BITS-1:0];
            REG_FILL_COLOUR: fill_val = data[PIXEL_BITS-1:0];
            default:         return;
        endcase
        restart_rect();
    endfunction

    function automatic bit blit_pixel(input logic [PIXEL_BITS-1:0] pix,
                                      output px_write_t wr);
        wr = '0;
        if (width_px == 0 || height_rows == 0)
            return 1'b0;
        if (skipping) begin
            gap_cnt = gap_cnt + 1'b1;
            if (gap_cnt >= src_gap) begin
                skipping = 1'b0;
                gap_cnt  = '0;
            end
            return 1'b0;
        end
        if (mode_sel == MODE_KEY_FILL || mode_sel == MODE_KEY_SOURCE) begin
            if (pix != 0) begin
                wr.en    = 1'b1;
                wr.value = (mode_sel == MODE_KEY_SOURCE) ? pix : fill_val;
            end
        end else begin
            wr.en    = 1'b1;
            wr.value = pix;
        end
        wr.addr = wr_ptr;
        wr_ptr  = wr_ptr + 1'b1;
        col_cnt = col_cnt + 1'b1;
        if (col_cnt >= width_px) begin
            col_cnt = '0;
            wr_ptr  = wr_ptr + {{(ADDR_BITS-COORD_BITS){1'b0}}, dst_gap};
            row_cnt = row_cnt + 1'b1;
            if (row_cnt >= height_rows) begin
                wr.last = 1'b1;
                restart_rect();
            end else if (src_gap != 0) begin
                skipping = 1'b1;
                gap_cnt  = '0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COORD_BITS'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return '0;
        if (r == 3)
            return '1;
        return PIXEL_BITS'($urandom);
    endfunction

    // Nothing in flight: all writes back and the pipe drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        if (!cfg_we)
            settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        write_reg(idx, data);
    endtask

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input check_t chk,
                              input px_write_t want, input int gap);
        px_write_t wr;
        bit        has;
        if (cfg_we)
            cfg_we <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        has = blit_pixel(pix, wr);
        sent_items++;
        case (chk)
            CHK_PRED:  if (has) pending_writes.push_back(wr);
            CHK_TYPED: pending_writes.push_back(want);
            default:   ;
        endcase
        @(negedge aclk);
    endtask

    task automatic random_phase(input bit wrap_test);
        logic [CFG_DATA_BITS-1:0] vals [8];
        int first, n, per_run, w, h, sk, k, idx;
        if (wrap_test) begin
            // One pixel per row with the largest row step walks the pointer past 2^20.
            vals[REG_DEST_X]      = COORD_BITS'($urandom_range(900, 1023));
            vals[REG_DEST_Y]      = '1;
            vals[REG_RECT_WIDTH]  = 10'd1;
            vals[REG_RECT_HEIGHT] = '1;
            vals[REG_SOURCE_SKIP] = '0;
            vals[REG_DEST_SKIP]   = '1;
        end else begin
            vals[REG_DEST_X] = pick_coord();
            vals[REG_DEST_Y] = pick_coord();
            k = $urandom_range(0, 15);
            vals[REG_RECT_WIDTH] = (k == 0) ? '0 : (k == 1) ? '1 :
                                   COORD_BITS'($urandom_range(1, 8));
            k = $urandom_range(0, 15);
            vals[REG_RECT_HEIGHT] = (k == 0) ? '0 : (k == 1) ? '1 :
                                    COORD_BITS'($urandom_range(1, 6));
            k = $urandom_range(0, 15);
            vals[REG_SOURCE_SKIP] = (k < 8) ? '0 : (k == 8) ? '1 :
                                    COORD_BITS'($urandom_range(1, 4));
            vals[REG_DEST_SKIP] = pick_coord();
        end
        vals[REG_DRAW_MODE]   = CFG_DATA_BITS'($urandom_range(0, 1023));
        vals[REG_FILL_COLOUR] = CFG_DATA_BITS'($urandom_range(0, 1023));

        first = $urandom_range(0, 7);
        for (k = 0; k < 8; k++) begin
            idx = (first + k) % 8;
            put_reg(CFG_INDEX_BITS'(idx), vals[idx]);
        end
        if ($urandom_range(0, 5) == 0)
            put_reg(CFG_INDEX_BITS'($urandom_range(8, 15)),
                    CFG_DATA_BITS'($urandom_range(0, 1023)));

        w  = int'(vals[REG_RECT_WIDTH]);
        h  = int'(vals[REG_RECT_HEIGHT]);
        sk = int'(vals[REG_SOURCE_SKIP]);
        if (wrap_test) begin
            n = 420;
        end else if (w == 0 || h == 0) begin
            n = 8;
        end else begin
            per_run = w * h + (h - 1) * sk;
            if (per_run <= 100)
                n = per_run * $urandom_range(1, 3) + $urandom_range(0, 4);
            else
                n = $urandom_range(30, 100);
        end

        source_eager = wrap_test || ($urandom_range(0, 3) == 0);
        hold_output  = wrap_test;
        for (k = 0; k < n; k++)
            send_pixel(pick_pixel(), CHK_PRED, '0,
                       source_eager ? 0 : $urandom_range(0, 14));
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_color_key_sprite_blitter: done, errors");
        $finish;
    end

    // Sink side: random back-pressure, steady stretches, one long hold.
    initial begin
        int gap, taken, k;
        taken = 0;
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge aclk);
                hold_output = 1'b0;
            end
            gap = sink_eager ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            if (taken % 40 == 0)
                sink_eager = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        px_write_t got, exp_wr;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[ADDR_BITS-1:0], m_tdata[ADDR_BITS +: PIXEL_BITS],
                    m_tuser, m_tlast};
            if (pending_writes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected write addr %h value %h en %b last %b",
                         $time, got.addr, got.value, got.en, got.last);
            end else begin
                exp_wr = pending_writes.pop_front();
                if (got !== exp_wr) begin
                    mismatches++;
                    $display("%0t: write mismatch: expected addr %h value %h en %b last %b,",
                             $time, exp_wr.addr, exp_wr.value, exp_wr.en, exp_wr.last);
                    $display("%0t:                 actual   addr %h value %h en %b last %b",
                             $time, got.addr, got.value, got.en, got.last);
                end
            end
        end
    end

    initial begin
        int r;
        clear_regs();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < $size(opening_rows); r++) begin
            if (opening_rows[r].kind == ROW_REG)
                put_reg(opening_rows[r].idx, opening_rows[r].data);
            else
                send_pixel(opening_rows[r].pix, opening_rows[r].chk,
                           opening_rows[r].want, $urandom_range(0, 14));
        end

        random_phase(1'b1);
        while (sent_items < TARGET_ITEMS)
            random_phase(1'b0);

        settle();
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("tb_color_key_sprite_blitter: done, clean");
        else
            $display("tb_color_key_sprite_blitter: done, errors");
        $finish;
    end

endmodule

FILE: color_key_sprite_blitter.f
src/ckb_pkg.sv
src/color_key_sprite_blitter.sv
bench/tb_color_key_sprite_blitter.sv
